// ===== design/rob_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rob_pkg;
	localparam int CoordW  = 20;
	localparam int CompW   = 16;
	localparam int DistW   = 24;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 60;
	localparam int DivNumW = 52;
	localparam int DivDenW = 32;
	localparam logic [DistW-1:0] DistMax = '1;

	localparam logic [CfgIdxW-1:0] RegEnabled    = 3'd0;
	localparam logic [CfgIdxW-1:0] RegCenter     = 3'd1;
	localparam logic [CfgIdxW-1:0] RegAxisRight  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegAxisUp     = 3'd3;
	localparam logic [CfgIdxW-1:0] RegAxisFwd    = 3'd4;
	localparam logic [CfgIdxW-1:0] RegHalfExtent = 3'd5;
	localparam logic [CfgIdxW-1:0] RegParLimit   = 3'd6;

	typedef struct packed {
		logic signed [CoordW-1:0] origin_x;
		logic signed [CoordW-1:0] origin_y;
		logic signed [CoordW-1:0] origin_z;
		logic signed [CompW-1:0]  dir_x;
		logic signed [CompW-1:0]  dir_y;
		logic signed [CompW-1:0]  dir_z;
	} ray_t;

	typedef struct packed {
		logic                     hit;
		logic [DistW-1:0]         entry_distance;
		logic signed [CoordW-1:0] hit_x;
		logic signed [CoordW-1:0] hit_y;
		logic signed [CoordW-1:0] hit_z;
	} isect_t;
endpackage
`default_nettype wire

// ===== design/rob_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Unsigned restoring divider, one quotient bit per stage, always advancing.
module rob_div (
	input  wire logic                          clk,
	input  wire logic [rob_pkg::DivNumW-1:0]   num,
	input  wire logic [rob_pkg::DivDenW-1:0]   den,
	output logic      [rob_pkg::DivNumW-1:0]   quo
);
	localparam int NW = rob_pkg::DivNumW;
	localparam int DW = rob_pkg::DivDenW;

	logic [DW-1:0] rem_s [NW+1];
	logic [NW-1:0] num_s [NW+1];
	logic [NW-1:0] quo_s [NW+1];
	logic [DW-1:0] den_s [NW+1];

	assign rem_s[0] = '0;
	assign num_s[0] = num;
	assign quo_s[0] = '0;
	assign den_s[0] = den;

	for (genvar j = 0; j < NW; j++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;
		logic [DW:0] diff;
		always_comb begin
			trial = {rem_s[j], num_s[j][NW-1]};
			ge    = trial >= {1'b0, den_s[j]};
			diff  = trial - {1'b0, den_s[j]};
		end
		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_s[j+1] <= {num_s[j][NW-2:0], 1'b0};
			quo_s[j+1] <= {quo_s[j][NW-2:0], ge};
			den_s[j+1] <= den_s[j];
		end
	end

	assign quo = quo_s[NW];
endmodule
`default_nettype wire

// ===== design/ray_obb_intersection.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ray against oriented box, slab method, fully pipelined.
// done is start carried through s1-s4, the divider delay line, s5-s7 and a register.
// Throughput: one ray per cycle; busy stays low. Depth set by the 52-stage dividers.
// The receiver cannot stall; results are never held back.
// Async active-low reset clears valid bits and sets enabled=1, parallel_limit=1.
module ray_obb_intersection (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire rob_pkg::ray_t                   ray,
	output logic                                 done,
	output rob_pkg::isect_t                      result,
	input  wire logic                            cfg_we,
	input  wire logic [rob_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [rob_pkg::CfgDataW-1:0]    cfg_data
);
	localparam int NW = rob_pkg::DivNumW;
	localparam int DW = rob_pkg::DivDenW;

	typedef struct packed {
		logic [2:0][19:0] org;
		logic [2:0][15:0] dir;
		logic [5:0]       qneg;
		logic [2:0]       par;
		logic [2:0]       pmiss;
	} side_t;

	logic        enabled_q;
	logic [59:0] center_q;
	logic [47:0] axis_q [3];
	logic [59:0] half_q;
	logic [7:0]  plim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			center_q  <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= '0;
			half_q    <= '0;
			plim_q    <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				rob_pkg::RegEnabled:    enabled_q <= cfg_data[0];
				rob_pkg::RegCenter:     center_q  <= cfg_data;
				rob_pkg::RegAxisRight:  axis_q[0] <= cfg_data[47:0];
				rob_pkg::RegAxisUp:     axis_q[1] <= cfg_data[47:0];
				rob_pkg::RegAxisFwd:    axis_q[2] <= cfg_data[47:0];
				rob_pkg::RegHalfExtent: half_q    <= cfg_data;
				rob_pkg::RegParLimit:   plim_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	logic accept;
	assign accept = start & ~busy;

	// s1: centre minus origin
	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic [2:0][19:0]  org_s1, org_s2, org_s3, org_s4;
	logic [2:0][15:0]  dir_s1, dir_s2, dir_s3, dir_s4;
	logic signed [20:0] delta_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		org_s1 <= {ray.origin_z, ray.origin_y, ray.origin_x};
		dir_s1 <= {ray.dir_z, ray.dir_y, ray.dir_x};
		for (int k = 0; k < 3; k++) begin
			delta_s1[k] <= $signed({center_q[20*k+19], center_q[20*k +: 20]})
				- $signed({(k == 0 ? ray.origin_x[19] : k == 1 ? ray.origin_y[19]
					: ray.origin_z[19]),
					(k == 0 ? ray.origin_x : k == 1 ? ray.origin_y : ray.origin_z)});
		end
	end

	// s2: axis projections, one product per axis component
	logic signed [36:0] pe_s2 [3][3];
	logic signed [31:0] pf_s2 [3][3];
	always_ff @(posedge clk) begin
		org_s2 <= org_s1;
		dir_s2 <= dir_s1;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				pe_s2[i][k] <= $signed(axis_q[i][16*k +: 16]) * delta_s1[k];
				pf_s2[i][k] <= $signed(axis_q[i][16*k +: 16]) * $signed(dir_s1[k]);
			end
		end
	end

	// s3: sums
	logic signed [38:0] e_s3 [3];
	logic signed [33:0] f_s3 [3];
	always_ff @(posedge clk) begin
		org_s3 <= org_s2;
		dir_s3 <= dir_s2;
		for (int i = 0; i < 3; i++) begin
			e_s3[i] <= 39'(pe_s2[i][0]) + 39'(pe_s2[i][1]) + 39'(pe_s2[i][2]);
			f_s3[i] <= 34'(pf_s2[i][0]) + 34'(pf_s2[i][1]) + 34'(pf_s2[i][2]);
		end
	end

	// s4: slab numerators and divisor as magnitude and sign
	logic signed [39:0] hs   [3];
	logic signed [39:0] ex   [3];
	logic signed [39:0] elo  [3];
	logic signed [39:0] ehi  [3];
	logic signed [53:0] nlo  [3];
	logic signed [53:0] nhi  [3];
	logic signed [33:0] fneg [3];
	logic [NW-1:0] num_s4 [6];
	logic [DW-1:0] den_s4 [3];
	logic [5:0]    qneg_s4;
	logic [2:0]    par_s4, pmiss_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hs[i]   = $signed({6'b0, half_q[20*i +: 20], 14'b0});
			ex[i]   = 40'(e_s3[i]);
			elo[i]  = ex[i] - hs[i];
			ehi[i]  = ex[i] + hs[i];
			nlo[i]  = $signed({elo[i], 14'b0});
			nhi[i]  = $signed({ehi[i], 14'b0});
			fneg[i] = -f_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		org_s4 <= org_s3;
		dir_s4 <= dir_s3;
		for (int i = 0; i < 3; i++) begin
			num_s4[2*i]   <= nlo[i][53] ? NW'(-nlo[i]) : NW'(nlo[i]);
			num_s4[2*i+1] <= nhi[i][53] ? NW'(-nhi[i]) : NW'(nhi[i]);
			den_s4[i]     <= f_s3[i][33] ? DW'(fneg[i]) : DW'(f_s3[i]);
			qneg_s4[2*i]   <= nlo[i][53] ^ f_s3[i][33];
			qneg_s4[2*i+1] <= nhi[i][53] ^ f_s3[i][33];
			par_s4[i]   <= (f_s3[i] == '0) ||
				((f_s3[i][33] ? DW'(fneg[i]) : DW'(f_s3[i])) < DW'({plim_q, 14'b0}));
			pmiss_s4[i] <= (ex[i] < -hs[i]) || (ex[i] > hs[i]);
		end
	end

	// dividers and matching delay line
	logic [NW-1:0] quo [6];
	for (genvar d = 0; d < 6; d++) begin : g_div
		rob_div u_div (
			.clk (clk),
			.num (num_s4[d]),
			.den (den_s4[d/2]),
			.quo (quo[d])
		);
	end

	logic [NW:0] vld_sd;
	side_t       side_sd [NW+1];
	assign vld_sd[0]  = valid_s4;
	assign side_sd[0] = '{org: org_s4, dir: dir_s4, qneg: qneg_s4, par: par_s4,
		pmiss: pmiss_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd[NW:1] <= '0;
		end else begin
			vld_sd[NW:1] <= vld_sd[NW-1:0];
		end
	end
	for (genvar j = 0; j < NW; j++) begin : g_side
		always_ff @(posedge clk) begin
			side_sd[j+1] <= side_sd[j];
		end
	end

	// s5: signed distances, ordered per slab
	logic signed [NW:0] q     [6];
	logic signed [NW:0] lo_s5 [3];
	logic signed [NW:0] hi_s5 [3];
	logic               valid_s5, valid_s6, valid_s7;
	logic [2:0][19:0]   org_s5, org_s6, org_s7;
	logic [2:0][15:0]   dir_s5, dir_s6, dir_s7;
	logic [2:0]         par_s5, pmiss_s5;

	always_comb begin
		for (int d = 0; d < 6; d++) begin
			q[d] = side_sd[NW].qneg[d] ? -$signed({1'b0, quo[d]}) : $signed({1'b0, quo[d]});
		end
	end

	always_ff @(posedge clk) begin
		org_s5   <= side_sd[NW].org;
		dir_s5   <= side_sd[NW].dir;
		par_s5   <= side_sd[NW].par;
		pmiss_s5 <= side_sd[NW].pmiss;
		for (int i = 0; i < 3; i++) begin
			lo_s5[i] <= (q[2*i] > q[2*i+1]) ? q[2*i+1] : q[2*i];
			hi_s5[i] <= (q[2*i] > q[2*i+1]) ? q[2*i] : q[2*i+1];
		end
	end

	// s6: narrow the interval
	logic signed [NW:0] tmin, tmax;
	logic               hit_s6;
	logic [23:0]        t_s6;
	always_comb begin
		tmin = '0;
		tmax = $signed({1'b0, {NW{1'b1}}});
		for (int i = 0; i < 3; i++) begin
			if (!par_s5[i]) begin
				if (lo_s5[i] > tmin) tmin = lo_s5[i];
				if (hi_s5[i] < tmax) tmax = hi_s5[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		org_s6 <= org_s5;
		dir_s6 <= dir_s5;
		hit_s6 <= enabled_q && ((par_s5 & pmiss_s5) == 3'b0) && !(tmin > tmax);
		t_s6   <= (tmin > $signed({{(NW-23){1'b0}}, rob_pkg::DistMax}))
			? rob_pkg::DistMax : tmin[23:0];
	end

	// s7: direction times distance
	logic signed [40:0] p_s7 [3];
	logic               hit_s7;
	logic [23:0]        t_s7;
	always_ff @(posedge clk) begin
		org_s7 <= org_s6;
		dir_s7 <= dir_s6;
		hit_s7 <= hit_s6;
		t_s7   <= t_s6;
		for (int k = 0; k < 3; k++) begin
			p_s7[k] <= $signed(dir_s6[k]) * $signed({1'b0, t_s6});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s5 <= vld_sd[NW];
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			done     <= valid_s7;
		end
	end

	// output: round half up, add origin, saturate
	logic signed [40:0] pr [3];
	logic signed [27:0] sum [3];
	logic signed [19:0] pt [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pr[k]  = p_s7[k] + 41'sd8192;
			sum[k] = 28'($signed(org_s7[k])) + 28'($signed(pr[k][40:14]));
			if (sum[k] > 28'sd524287) begin
				pt[k] = 20'sd524287;
			end else if (sum[k] < -28'sd524288) begin
				pt[k] = -20'sd524288;
			end else begin
				pt[k] = sum[k][19:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		result.hit            <= hit_s7;
		result.entry_distance <= hit_s7 ? t_s7 : '0;
		result.hit_x          <= hit_s7 ? pt[0] : '0;
		result.hit_y          <= hit_s7 ? pt[1] : '0;
		result.hit_z          <= hit_s7 ? pt[2] : '0;
	end

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |-> result.entry_distance == '0 && result.hit_x == '0 &&
			result.hit_y == '0 && result.hit_z == '0)
		else $error("miss with nonzero payload");
	a_front_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ##3 valid_s4)
		else $error("item lost in front stages");
	a_miss_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && !hit_s6 |-> ##2 (done && !result.hit))
		else $error("miss not delivered");
`endif
endmodule
`default_nettype wire

// ===== bench/isect_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module isect_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            busy,
	input  wire rob_pkg::ray_t   ray,
	input  wire logic            done,
	input  wire rob_pkg::isect_t result,
	input  wire logic            cfg_we,
	input  wire logic [rob_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [rob_pkg::CfgDataW-1:0] cfg_data,
	output int                   errors,
	output int                   pending,
	output int                   hits_seen,
	output int                   results_seen
);
	logic        en_q;
	logic [59:0] centre_q, half_q;
	logic [47:0] axes_q [3];
	logic [7:0]  plim_q;
	rob_pkg::isect_t awaited [$];

	function automatic logic signed [63:0] round_q14(input logic signed [63:0] p);
		logic signed [63:0] q;
		q = p + 64'sd8192;
		if (q >= 0)
			return q >>> 14;
		return -((-q + 64'sd16383) >>> 14);
	endfunction

	function automatic rob_pkg::isect_t trace_ray(input rob_pkg::ray_t r);
		rob_pkg::isect_t o;
		logic signed [63:0] org [3], dir [3], dlt [3];
		logic signed [63:0] tmin, tmax, lim, e, f, h, af, t1, t2, s, a, p;
		logic ok;
		tmin = 0;
		tmax = 64'sh7FFF_FFFF_FFFF_FFFF;
		lim = $signed({56'd0, plim_q}) * 64'sd16384;
		ok = en_q;
		org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
		dir[0] = r.dir_x; dir[1] = r.dir_y; dir[2] = r.dir_z;
		for (int k = 0; k < 3; k++)
			dlt[k] = $signed(centre_q[k*20 +: 20]) - org[k];
		for (int i = 0; i < 3; i++) begin
			if (ok) begin
				e = 0;
				f = 0;
				for (int k = 0; k < 3; k++) begin
					a = $signed(axes_q[i][k*16 +: 16]);
					e += a * dlt[k];
					f += a * dir[k];
				end
				h = $signed({44'd0, half_q[i*20 +: 20]}) * 64'sd16384;
				af = f < 0 ? -f : f;
				if (f == 0 || af < lim) begin
					if (e < -h || e > h)
						ok = 0;
				end else begin
					t1 = ((e - h) * 64'sd16384) / f;
					t2 = ((e + h) * 64'sd16384) / f;
					if (t1 > t2) begin
						s = t1; t1 = t2; t2 = s;
					end
					if (t2 < tmax) tmax = t2;
					if (t1 > tmin) tmin = t1;
					if (tmin > tmax) ok = 0;
				end
			end
		end
		o = '0;
		if (ok) begin
			if (tmin > 64'sd16777215)
				tmin = 64'sd16777215;
			o.hit = 1'b1;
			o.entry_distance = tmin[23:0];
			for (int k = 0; k < 3; k++) begin
				p = org[k] + round_q14(dir[k] * tmin);
				if (p > 64'sd524287) p = 64'sd524287;
				if (p < -64'sd524288) p = -64'sd524288;
				case (k)
					0: o.hit_x = p[19:0];
					1: o.hit_y = p[19:0];
					default: o.hit_z = p[19:0];
				endcase
			end
		end
		return o;
	endfunction

	assign pending = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		rob_pkg::isect_t want;
		if (!arst_n) begin
			en_q <= 1'b1;
			centre_q <= '0;
			half_q <= '0;
			axes_q[0] <= '0; axes_q[1] <= '0; axes_q[2] <= '0;
			plim_q <= 8'd1;
			errors <= 0;
			hits_seen <= 0;
			results_seen <= 0;
		end else begin
			if (done) begin
				results_seen <= results_seen + 1;
				if (awaited.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("unexpected result %h", result);
				end else begin
					want = awaited.pop_front();
					if (result.hit) hits_seen <= hits_seen + 1;
					if (result.hit !== want.hit
						|| result.entry_distance !== want.entry_distance
						|| result.hit_x !== want.hit_x || result.hit_y !== want.hit_y
						|| result.hit_z !== want.hit_z) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("mismatch: hit %b/%b dist %0d/%0d pt %0d,%0d,%0d / %0d,%0d,%0d",
								want.hit, result.hit, want.entry_distance,
								result.entry_distance, want.hit_x, want.hit_y,
								want.hit_z, result.hit_x, result.hit_y, result.hit_z);
					end
				end
			end
			if (start && !busy)
				awaited = {awaited, trace_ray(ray)};
			if (cfg_we) begin
				case (cfg_index)
					rob_pkg::RegEnabled:    en_q <= cfg_data[0];
					rob_pkg::RegCenter:     centre_q <= cfg_data[59:0];
					rob_pkg::RegAxisRight:  axes_q[0] <= cfg_data[47:0];
					rob_pkg::RegAxisUp:     axes_q[1] <= cfg_data[47:0];
					rob_pkg::RegAxisFwd:    axes_q[2] <= cfg_data[47:0];
					rob_pkg::RegHalfExtent: half_q <= cfg_data[59:0];
					rob_pkg::RegParLimit:   plim_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	logic clk, arst_n, start, busy, done, cfg_we;
	rob_pkg::ray_t ray;
	rob_pkg::isect_t result;
	logic [rob_pkg::CfgIdxW-1:0] cfg_index;
	logic [rob_pkg::CfgDataW-1:0] cfg_data;
	int errors, pending, hits_seen, results_seen, items_sent;

	ray_obb_intersection dut (.*);
	isect_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("testbench NOT OK");
		$finish;
	end

	task automatic write_reg(input logic [rob_pkg::CfgIdxW-1:0] idx,
		input logic [rob_pkg::CfgDataW-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// drains the pipeline so register writes never meet a ray in flight
	task automatic settle();
		while (pending != 0) @(negedge clk);
		repeat (70) @(negedge clk);
	endtask

	task automatic send_ray(input rob_pkg::ray_t r, input bit gaps);
		int gap;
		gap = gaps && $urandom_range(0, 3) != 0 ? $urandom_range(0, 12) : 0;
		repeat (gap) @(negedge clk);
		start = 1'b1;
		ray = r;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return $signed(16'($urandom_range(0, 8)) - 16'sd4);
			default: return $signed(16'($urandom_range(0, 32768)) - 16'sd16384);
		endcase
	endfunction

	function automatic logic signed [19:0] rand_coord(input bit wide);
		if (wide)
			return $signed(20'($urandom));
		return $signed(20'($urandom_range(0, 20000))) - 20'sd10000;
	endfunction

	function automatic rob_pkg::ray_t rand_ray();
		rob_pkg::ray_t r;
		bit wide;
		wide = $urandom_range(0, 4) == 0;
		r.origin_x = rand_coord(wide);
		r.origin_y = rand_coord(wide);
		r.origin_z = rand_coord(wide);
		r.dir_x = rand_comp();
		r.dir_y = rand_comp();
		r.dir_z = rand_comp();
		return r;
	endfunction

	// box: either axis aligned or with random axes, small or extreme extents
	task automatic rand_box(input int mode);
		logic [47:0] ax [3];
		logic [59:0] half;
		for (int i = 0; i < 3; i++) begin
			if (mode == 0) begin
				ax[i] = '0;
				ax[i][i*16 +: 16] = 16'sd16384;
			end else begin
				ax[i] = {rand_comp(), rand_comp(), rand_comp()};
			end
		end
		if (mode == 2)
			half = {60{1'b1}};
		else
			half = {20'($urandom_range(0, 8000)), 20'($urandom_range(0, 8000)),
				20'($urandom_range(0, 8000))};
		write_reg(rob_pkg::RegCenter, {rand_coord(mode == 2), rand_coord(0), rand_coord(0)});
		write_reg(rob_pkg::RegAxisRight, ax[0]);
		write_reg(rob_pkg::RegAxisUp, ax[1]);
		write_reg(rob_pkg::RegAxisFwd, ax[2]);
		write_reg(rob_pkg::RegHalfExtent, half);
		write_reg(rob_pkg::RegParLimit, mode == 2 ? 8'hFF : 8'($urandom_range(0, 40)));
		write_reg(rob_pkg::RegEnabled, 1'b1);
	endtask

	initial begin
		rob_pkg::ray_t r;
		start = 0;
		ray = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		items_sent = 0;
		arst_n = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset state: degenerate box, then a unit cube around origin
		r = '{0, 0, 0, 16384, 0, 0};
		send_ray(r, 0);
		settle();
		rand_box(0);
		write_reg(rob_pkg::RegCenter, '0);
		write_reg(rob_pkg::RegHalfExtent, {20'd1024, 20'd1024, 20'd1024});
		write_reg(rob_pkg::RegParLimit, 8'd0);
		send_ray('{0, 0, 0, 16384, 0, 0}, 0);                    // origin inside
		send_ray('{-20'sd10240, 0, 0, 16384, 0, 0}, 0);          // plain hit
		send_ray('{-20'sd10240, 0, 0, -16384, 0, 0}, 0);         // behind
		send_ray('{-20'sd10240, 20'sd5000, 0, 16384, 0, 0}, 0);  // zero cosine, outside
		send_ray('{20'sh80000, 0, 0, 16384, 0, 0}, 0);           // far entry
		send_ray('{20'sh80000, 20'sh80000, 20'sh80000, 16384, 16384, 16384}, 0);
		send_ray('{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, -16384, -16384, -16384}, 0);
		send_ray('{-20'sd3000, 0, 0, 1, 0, 0}, 0);               // tiny cosine
		send_ray('{-20'sd3000, 0, 0, 16'sh7FFF, 16'sh8000, 0}, 0); // non-unit
		settle();
		write_reg(rob_pkg::RegParLimit, 8'hFF);
		send_ray('{-20'sd3000, 0, 0, 100, 0, 0}, 0);
		send_ray('{0, 0, 0, 100, 0, 0}, 0);
		settle();
		write_reg(rob_pkg::RegEnabled, 1'b0);
		send_ray('{0, 0, 0, 16384, 0, 0}, 0);
		settle();
		write_reg(3'd7, {60{1'b1}});

		for (int phase = 0; phase < 12; phase++) begin
			rand_box(phase % 3);
			if (phase == 5) write_reg(rob_pkg::RegEnabled, 1'b0);
			for (int n = 0; n < 160; n++)
				send_ray(rand_ray(), phase % 4 != 1);
			settle();
		end

		$display("%0d rays sent, %0d results, %0d hits, over 12 box settings",
			items_sent, results_seen, hits_seen);
		if (errors == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
